### design/clps_pkg.sv
// ----------------------------------------------------------------------------
// clps_pkg: shared types and constants of the link parameter scanner
// Register indexes, the result record and the band code to Mbps table.
// ----------------------------------------------------------------------------
package clps_pkg;

	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_RATE_CODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_INVERTED  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SETTLE_TICKS      = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_AUTO_SCAN_ENABLE  = 2'd3;

	localparam logic [5:0]  RST_DEFAULT_RATE_CODE = 6'd17;
	localparam logic        RST_DEFAULT_INVERTED  = 1'b0;
	localparam logic [15:0] RST_SETTLE_TICKS      = 16'd120;
	localparam logic        RST_AUTO_SCAN_ENABLE  = 1'b1;

	typedef struct packed {
		logic        scan_running;
		logic        link_locked;
		logic [7:0]  step_number;
		logic [5:0]  rate_code;
		logic        lanes_inverted;
		logic        two_lanes;
		logic [11:0] rate_mbps;
		logic        apply_strobe;
	} result_t;

	// Per-lane rate of each PHY band code. Codes past the end read the top rate.
	function automatic logic [11:0] band_mbps(input logic [5:0] code);
		logic [11:0] mbps;
		case (code)
			6'd0:  mbps = 12'd80;
			6'd1:  mbps = 12'd90;
			6'd2:  mbps = 12'd100;
			6'd3:  mbps = 12'd110;
			6'd4:  mbps = 12'd120;
			6'd5:  mbps = 12'd130;
			6'd6:  mbps = 12'd140;
			6'd7:  mbps = 12'd150;
			6'd8:  mbps = 12'd160;
			6'd9:  mbps = 12'd170;
			6'd10: mbps = 12'd180;
			6'd11: mbps = 12'd190;
			6'd12: mbps = 12'd205;
			6'd13: mbps = 12'd220;
			6'd14: mbps = 12'd235;
			6'd15: mbps = 12'd250;
			6'd16: mbps = 12'd275;
			6'd17: mbps = 12'd300;
			6'd18: mbps = 12'd325;
			6'd19: mbps = 12'd350;
			6'd20: mbps = 12'd400;
			6'd21: mbps = 12'd450;
			6'd22: mbps = 12'd500;
			6'd23: mbps = 12'd550;
			6'd24: mbps = 12'd600;
			6'd25: mbps = 12'd650;
			6'd26: mbps = 12'd700;
			6'd27: mbps = 12'd750;
			6'd28: mbps = 12'd800;
			6'd29: mbps = 12'd850;
			6'd30: mbps = 12'd900;
			6'd31: mbps = 12'd950;
			6'd32: mbps = 12'd1000;
			6'd33: mbps = 12'd1050;
			6'd34: mbps = 12'd1100;
			6'd35: mbps = 12'd1150;
			6'd36: mbps = 12'd1200;
			6'd37: mbps = 12'd1250;
			6'd38: mbps = 12'd1300;
			6'd39: mbps = 12'd1350;
			6'd40: mbps = 12'd1400;
			6'd41: mbps = 12'd1450;
			6'd42: mbps = 12'd1500;
			6'd43: mbps = 12'd1550;
			6'd44: mbps = 12'd1600;
			6'd45: mbps = 12'd1650;
			6'd46: mbps = 12'd1700;
			6'd47: mbps = 12'd1750;
			6'd48: mbps = 12'd1800;
			6'd49: mbps = 12'd1850;
			6'd50: mbps = 12'd1900;
			6'd51: mbps = 12'd1950;
			6'd52: mbps = 12'd2000;
			6'd53: mbps = 12'd2050;
			6'd54: mbps = 12'd2100;
			6'd55: mbps = 12'd2150;
			6'd56: mbps = 12'd2200;
			6'd57: mbps = 12'd2250;
			6'd58: mbps = 12'd2300;
			6'd59: mbps = 12'd2350;
			6'd60: mbps = 12'd2400;
			6'd61: mbps = 12'd2450;
			default: mbps = 12'd2500;
		endcase
		return mbps;
	endfunction

endpackage

### design/csi_link_parameter_scanner.sv
// ----------------------------------------------------------------------------
// csi_link_parameter_scanner
// Sweeps PHY band code, lane mapping and lane count until a frame start shows.
// ----------------------------------------------------------------------------
// Usage:
// Each input request is one millisecond tick carrying arm and frame_start.
// Arm applies step zero (configured default band code and lane mapping, two
// lanes) and restarts the settle countdown. With auto scan on, each candidate
// is judged settle_ticks ticks after it is applied: a frame start seen since
// the apply locks the scan, otherwise the next step, if any, is applied.
// Every tick gives one result request: status and the applied combination
// after that tick, with its per-lane Mbps.
// Throughput is one tick per cycle while in_stall is low. Each tick's result
// is registered in the result register (or the skid register under out_stall);
// the whole tick update sits between scan state registers and that register.
// A two-entry output stage (result register plus skid register) lets a tick
// be accepted while a result waits; in_stall rises only when both are full.
// Reset clears the scan state and loads the register defaults; no result is
// pending after reset. Configuration writes are taken on any cycle with
// cfg_wr_en high and should be made while the scanner is idle.
// ----------------------------------------------------------------------------
module csi_link_parameter_scanner #(
	parameter int unsigned RATE_CODES = 63
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [clps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [clps_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                   in_valid,
	output logic                                   in_stall,
	input  logic                                   arm,
	input  logic                                   frame_start,
	output logic                                   out_valid,
	input  logic                                   out_stall,
	output logic                                   scan_running,
	output logic                                   link_locked,
	output logic [7:0]                             step_number,
	output logic [5:0]                             rate_code,
	output logic                                   lanes_inverted,
	output logic                                   two_lanes,
	output logic [11:0]                            rate_mbps,
	output logic                                   apply_strobe
);

	localparam int unsigned TOTAL_STEPS = 1 + 4 * RATE_CODES;
	localparam int unsigned STEP_W = $clog2(TOTAL_STEPS + 1);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(TOTAL_STEPS);
	localparam logic [5:0] RATE_LAST = 6'(RATE_CODES - 1);

	// Configuration registers
	logic [5:0]  def_rate_q;
	logic        def_inv_q;
	logic [15:0] settle_ticks_q;
	logic        auto_scan_q;

	// Scan state
	logic              running_q, running_n;
	logic              locked_q, locked_n;
	logic [STEP_W-1:0] step_q, step_n;
	logic [15:0]       settle_q, settle_n;
	logic              seen_q, seen_n;
	logic [5:0]        rate_q, rate_n;
	logic              inv_q, inv_n;
	logic              two_q, two_n;
	logic              strobe_n;
	logic [STEP_W-1:0] step_inc;

	clps_pkg::result_t res_n;
	clps_pkg::result_t out_res_q;
	clps_pkg::result_t skid_res_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              in_take;
	logic              out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			def_rate_q     <= clps_pkg::RST_DEFAULT_RATE_CODE;
			def_inv_q      <= clps_pkg::RST_DEFAULT_INVERTED;
			settle_ticks_q <= clps_pkg::RST_SETTLE_TICKS;
			auto_scan_q    <= clps_pkg::RST_AUTO_SCAN_ENABLE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				clps_pkg::REG_DEFAULT_RATE_CODE: def_rate_q <= cfg_data[5:0];
				clps_pkg::REG_DEFAULT_INVERTED:  def_inv_q <= cfg_data[0];
				clps_pkg::REG_SETTLE_TICKS:      settle_ticks_q <= cfg_data;
				clps_pkg::REG_AUTO_SCAN_ENABLE:  auto_scan_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign step_inc = step_q + STEP_W'(1);

	always_comb begin
		running_n = running_q;
		locked_n  = locked_q;
		step_n    = step_q;
		settle_n  = settle_q;
		seen_n    = seen_q;
		rate_n    = rate_q;
		inv_n     = inv_q;
		two_n     = two_q;
		strobe_n  = 1'b0;
		if (arm) begin
			step_n    = '0;
			locked_n  = 1'b0;
			running_n = auto_scan_q;
			rate_n    = def_rate_q;
			inv_n     = def_inv_q;
			two_n     = 1'b1;
			seen_n    = 1'b0;
			settle_n  = settle_ticks_q;
			strobe_n  = 1'b1;
		end else if (running_q) begin
			seen_n = seen_q | frame_start;
			if (settle_q > 16'd1) begin
				settle_n = settle_q - 16'd1;
			end else begin
				settle_n = '0;
				if (seen_n) begin
					running_n = 1'b0;
					locked_n  = 1'b1;
				end else if (step_inc >= STEP_LAST) begin
					step_n    = STEP_LAST;
					running_n = 1'b0;
					locked_n  = 1'b0;
				end else begin
					step_n   = step_inc;
					seen_n   = 1'b0;
					settle_n = settle_ticks_q;
					strobe_n = 1'b1;
					// Steps walk mapping fastest, then band code, then lane count,
					// so each candidate follows from the one applied before it.
					if (step_q == '0) begin
						rate_n = '0;
						inv_n  = 1'b0;
						two_n  = 1'b1;
					end else if (!inv_q) begin
						inv_n = 1'b1;
					end else begin
						inv_n = 1'b0;
						if (rate_q == RATE_LAST) begin
							rate_n = '0;
							two_n  = 1'b0;
						end else begin
							rate_n = rate_q + 6'd1;
						end
					end
				end
			end
		end
	end

	always_comb begin
		res_n.scan_running   = running_n;
		res_n.link_locked    = locked_n;
		res_n.step_number    = 8'(step_n);
		res_n.rate_code      = rate_n;
		res_n.lanes_inverted = inv_n;
		res_n.two_lanes      = two_n;
		res_n.rate_mbps      = clps_pkg::band_mbps(rate_n);
		res_n.apply_strobe   = strobe_n;
	end

	assign in_stall = skid_valid_q;
	assign in_take  = in_valid && !skid_valid_q;
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q <= 1'b0;
			locked_q  <= 1'b0;
			step_q    <= '0;
			settle_q  <= '0;
			seen_q    <= 1'b0;
			rate_q    <= '0;
			inv_q     <= 1'b0;
			two_q     <= 1'b0;
		end else if (in_take) begin
			running_q <= running_n;
			locked_q  <= locked_n;
			step_q    <= step_n;
			settle_q  <= settle_n;
			seen_q    <= seen_n;
			rate_q    <= rate_n;
			inv_q     <= inv_n;
			two_q     <= two_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || in_take;
			skid_valid_q <= 1'b0;
		end else if (in_take) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_res_q <= skid_res_q;
			end else if (in_take) begin
				out_res_q <= res_n;
			end
		end else if (in_take) begin
			skid_res_q <= res_n;
		end
	end

	assign out_valid      = out_valid_q;
	assign scan_running   = out_res_q.scan_running;
	assign link_locked    = out_res_q.link_locked;
	assign step_number    = out_res_q.step_number;
	assign rate_code      = out_res_q.rate_code;
	assign lanes_inverted = out_res_q.lanes_inverted;
	assign two_lanes      = out_res_q.two_lanes;
	assign rate_mbps      = out_res_q.rate_mbps;
	assign apply_strobe   = out_res_q.apply_strobe;

endmodule
